FILE: src/kxy_pkg.sv
package kxy_pkg;

  // default datapath precision and fixed field widths
  localparam int FRAC_BITS_DEF = 16;
  localparam int K_W = 16;
  localparam int KC_W = 15;
  localparam int OUT_W = 16;

  // accurate range of the cubic fit and its band splits
  localparam int K_MIN = 1667;
  localparam int K_MAX = 25000;
  localparam int K_SPLIT_HI = 4000;
  localparam int K_SPLIT_LO = 2222;

  // numerator of the reciprocal, u = 1000 / K
  localparam int RECIP_NUM = 1000;

  // coefficient scale of the decimal tables
  localparam longint DEC_DEN = 64'sd100000000;

  // y coefficient band codes
  localparam logic [1:0] Y_SET_A = 2'd0;
  localparam logic [1:0] Y_SET_B = 2'd1;
  localparam logic [1:0] Y_SET_C = 2'd2;

  typedef struct packed {
    logic       x_hi;
    logic [1:0] y_set;
  } kxy_sel_t;

  // decimal coefficients scaled by 1e8, order c3, c2, c1, c0
  localparam longint X_LO_DEC [4] = '{-26612390, -23435800, 87769560, 17991000};
  localparam longint X_HI_DEC [4] = '{-302584690, 210703790, 22263470, 24039000};
  localparam longint Y_A_DEC [4] = '{-110638140, -134811020, 218555832, -20219683};
  localparam longint Y_B_DEC [4] = '{-95494760, -137418593, 209137015, -16748867};
  localparam longint Y_C_DEC [4] = '{308175800, -587338670, 375112997, -37001483};

  // decimal coefficient to signed fixed point, ties away from zero
  function automatic longint coef_fx(longint d, int f);
    longint mag;
    longint q;
    mag = (d < 0) ? -d : d;
    q = ((mag <<< f) + DEC_DEN / 2) / DEC_DEN;
    return (d < 0) ? -q : q;
  endfunction

endpackage

FILE: src/kxy_temp_if.sv
interface kxy_temp_if import kxy_pkg::*; ();
  logic           valid;
  logic           ready;
  logic [K_W-1:0] kelvin;

  modport source (output valid, output kelvin, input ready);
  modport sink (input valid, input kelvin, output ready);
endinterface

FILE: src/kxy_xy_if.sv
interface kxy_xy_if import kxy_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OUT_W-1:0] cie_x;
  logic [OUT_W-1:0] cie_y;

  modport source (output valid, output cie_x, output cie_y, input ready);
  modport sink (input valid, input cie_x, input cie_y, output ready);
endinterface

FILE: src/kxy_recip.sv
module kxy_recip import kxy_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SW = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  adv,
  input  logic                  in_valid,
  input  logic [KC_W-1:0]       k,
  input  logic [FRAC_BITS+9:0]  num,
  input  logic [SW-1:0]         side,
  output logic                  out_valid,
  output logic [FRAC_BITS-1:0]  u,
  output logic [SW-1:0]         out_side
);

  localparam int NW = FRAC_BITS + 10;

  logic              vld  [NW+1];
  logic [KC_W-1:0]   rem  [NW+1];
  logic [NW-1:0]     numr [NW+1];
  logic [NW-1:0]     quo  [NW+1];
  logic [KC_W-1:0]   kr   [NW+1];
  logic [SW-1:0]     sd   [NW+1];

  // stage zero is the incoming beat
  assign vld[0]  = in_valid;
  assign rem[0]  = '0;
  assign numr[0] = num;
  assign quo[0]  = '0;
  assign kr[0]   = k;
  assign sd[0]   = side;

  // one restoring quotient bit per stage
  for (genvar s = 0; s < NW; s++) begin : g_stage
    logic [KC_W:0] r2;
    logic          ge;

    assign r2 = {rem[s], numr[s][NW-1]};
    assign ge = (r2 >= {1'b0, kr[s]});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem[s+1]  <= ge ? KC_W'(r2 - {1'b0, kr[s]}) : r2[KC_W-1:0];
        numr[s+1] <= {numr[s][NW-2:0], 1'b0};
        quo[s+1]  <= {quo[s][NW-2:0], ge};
        kr[s+1]   <= kr[s];
        sd[s+1]   <= sd[s];
      end
    end
  end

  // quotient stays below 2^F over the clamped range
  assign out_valid = vld[NW];
  assign u         = quo[NW][FRAC_BITS-1:0];
  assign out_side  = sd[NW];

endmodule

FILE: src/kxy_horner.sv
module kxy_horner import kxy_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int SW = 2
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  logic                             in_valid,
  input  logic signed [FRAC_BITS+3:0]      v,
  input  logic [3:0][FRAC_BITS+3:0]        coef,
  input  logic [SW-1:0]                    side,
  output logic                             out_valid,
  output logic signed [FRAC_BITS+3:0]      acc_out,
  output logic [SW-1:0]                    out_side
);

  localparam int AW = FRAC_BITS + 4;
  localparam int PW = 2 * AW;
  localparam logic [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

  logic                     vld [7];
  logic signed [AW-1:0]     vv  [7];
  logic [3:0][AW-1:0]       cf  [7];
  logic [SW-1:0]            sd  [7];
  logic signed [AW-1:0]     acc [4];
  logic signed [PW-1:0]     prod [3];

  assign vld[0] = in_valid;
  assign vv[0]  = v;
  assign cf[0]  = coef;
  assign sd[0]  = side;
  assign acc[0] = $signed(coef[3]);

  for (genvar j = 0; j < 3; j++) begin : g_step
    logic signed [PW-1:0] rnd;
    logic signed [PW-1:0] shr;

    // round to nearest, ties away from zero
    assign rnd = prod[j] + $signed(HALF) - $signed(PW'(prod[j][PW-1]));
    assign shr = rnd >>> FRAC_BITS;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[2*j+1] <= 1'b0;
        vld[2*j+2] <= 1'b0;
      end else if (adv) begin
        vld[2*j+1] <= vld[2*j];
        vld[2*j+2] <= vld[2*j+1];
      end
    end

    // multiply stage, then round and add stage
    always_ff @(posedge clk) begin
      if (adv) begin
        prod[j]    <= acc[j] * vv[2*j];
        vv[2*j+1]  <= vv[2*j];
        cf[2*j+1]  <= cf[2*j];
        sd[2*j+1]  <= sd[2*j];
        acc[j+1]   <= shr[AW-1:0] + $signed(cf[2*j+1][2-j]);
        vv[2*j+2]  <= vv[2*j+1];
        cf[2*j+2]  <= cf[2*j+1];
        sd[2*j+2]  <= sd[2*j+1];
      end
    end
  end

  assign out_valid = vld[6];
  assign acc_out   = acc[3];
  assign out_side  = sd[6];

endmodule

FILE: src/kelvin_to_cie_xy.sv
// kelvin_to_cie_xy: colour temperature to CIE 1931 chromaticity (x, y)
// temp channel: one beat carries kelvin, clamped inside to 1667..25000 K
// chroma channel: one beat carries cie_x and cie_y as unsigned Q0.16
// each accepted temp beat gives exactly one chroma beat, in order
// the pipeline is one clamp stage, FRAC_BITS + 10 restoring divider
// stages for 1000/K, six stages for the cubic in 1/K, six for the cubic
// in x, and the output register
// throughput is one beat per cycle while temp.ready is high; every stage
// is a plain register stage with its own valid bit and one multiplier at most
// when the receiver stalls, the output register holds its beat and the
// pipeline keeps taking beats until its last stage is full; only then
// does temp.ready drop, and nothing is lost or repeated
// reset clears all valid bits; no other register is reset
module kelvin_to_cie_xy import kxy_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  kxy_temp_if.sink  temp,
  kxy_xy_if.source  chroma
);

  localparam int F = FRAC_BITS;
  localparam int AW = F + 4;
  localparam int NW = F + 10;
  localparam int MW = AW + 16;
  localparam int SH_R = (F > 16) ? F - 16 : 0;
  localparam int SH_L = (F < 16) ? 16 - F : 0;
  localparam int RND = (1 << SH_R) >> 1;

  function automatic logic [3:0][AW-1:0] coefs(input longint d [4]);
    logic [3:0][AW-1:0] r;
    for (int i = 0; i < 4; i++) begin
      r[3-i] = AW'(coef_fx(d[i], F));
    end
    return r;
  endfunction

  localparam logic [3:0][AW-1:0] CX_LO = coefs(X_LO_DEC);
  localparam logic [3:0][AW-1:0] CX_HI = coefs(X_HI_DEC);
  localparam logic [3:0][AW-1:0] CY_A = coefs(Y_A_DEC);
  localparam logic [3:0][AW-1:0] CY_B = coefs(Y_B_DEC);
  localparam logic [3:0][AW-1:0] CY_C = coefs(Y_C_DEC);

  // output conversion to Q0.16 with saturation
  function automatic logic [OUT_W-1:0] to_q16(input logic signed [AW-1:0] a);
    logic [MW-1:0] m;
    m = {{(MW-AW){1'b0}}, a};
    m = ((m + MW'(RND)) >> SH_R) << SH_L;
    if (a < 0) begin
      return '0;
    end else if (m > MW'(16'hFFFF)) begin
      return '1;
    end else begin
      return m[OUT_W-1:0];
    end
  endfunction

  logic                 adv;
  logic                 v0;
  logic [KC_W-1:0]      k0;
  logic [NW-1:0]        num0;
  kxy_sel_t             sel0;
  logic [K_W-1:0]       kc;
  kxy_sel_t             sel_c;

  logic                 uv;
  logic [F-1:0]         u;
  kxy_sel_t             usel;

  logic                 xv;
  logic signed [AW-1:0] xacc;
  logic [1:0]           xyset;
  logic [3:0][AW-1:0]   cy;

  logic                 yv;
  logic signed [AW-1:0] yacc;
  logic [AW-1:0]        yx;

  logic                 ov;
  logic [OUT_W-1:0]     ox;
  logic [OUT_W-1:0]     oy;

  // pipeline moves unless the last stage is full behind a stalled output
  assign adv = !(ov && !chroma.ready && yv);
  assign temp.ready = adv;

  // clamp and band selection
  always_comb begin
    priority if (temp.kelvin < K_W'(K_MIN)) begin
      kc = K_W'(K_MIN);
    end else if (temp.kelvin > K_W'(K_MAX)) begin
      kc = K_W'(K_MAX);
    end else begin
      kc = temp.kelvin;
    end
    sel_c.x_hi = (kc >= K_W'(K_SPLIT_HI));
    priority if (kc < K_W'(K_SPLIT_LO)) begin
      sel_c.y_set = Y_SET_A;
    end else if (kc < K_W'(K_SPLIT_HI)) begin
      sel_c.y_set = Y_SET_B;
    end else begin
      sel_c.y_set = Y_SET_C;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (adv) begin
      v0 <= temp.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      k0   <= kc[KC_W-1:0];
      num0 <= (NW'(RECIP_NUM) << F) + NW'(kc >> 1);
      sel0 <= sel_c;
    end
  end

  // u = 1000 / K rounded
  kxy_recip #(.FRAC_BITS(F), .SW(3)) u_recip (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (v0),
    .k         (k0),
    .num       (num0),
    .side      (sel0),
    .out_valid (uv),
    .u         (u),
    .out_side  (usel)
  );

  // x as a cubic in u
  kxy_horner #(.FRAC_BITS(F), .SW(2)) u_horner_x (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (uv),
    .v         ($signed({{(AW-F){1'b0}}, u})),
    .coef      (usel.x_hi ? CX_HI : CX_LO),
    .side      (usel.y_set),
    .out_valid (xv),
    .acc_out   (xacc),
    .out_side  (xyset)
  );

  always_comb begin
    unique case (xyset)
      Y_SET_A: cy = CY_A;
      Y_SET_B: cy = CY_B;
      default: cy = CY_C;
    endcase
  end

  // y as a cubic in x, x rides along
  kxy_horner #(.FRAC_BITS(F), .SW(AW)) u_horner_y (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (xv),
    .v         (xacc),
    .coef      (cy),
    .side      (xacc),
    .out_valid (yv),
    .acc_out   (yacc),
    .out_side  (yx)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (!ov || chroma.ready) begin
      ov <= yv;
    end
  end

  always_ff @(posedge clk) begin
    if ((!ov || chroma.ready) && yv) begin
      ox <= to_q16($signed(yx));
      oy <= to_q16(yacc);
    end
  end

  assign chroma.valid = ov;
  assign chroma.cie_x = ox;
  assign chroma.cie_y = oy;

  // checks
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    (chroma.valid && !chroma.ready && yv) |-> !temp.ready)
    else $error("input taken while last stage is blocked");

  a_clamped: assert property (@(posedge clk) disable iff (rst)
    v0 |-> (k0 >= KC_W'(K_MIN) && k0 <= KC_W'(K_MAX)))
    else $error("temperature outside clamp range");

  a_recip_nonzero: assert property (@(posedge clk) disable iff (rst)
    uv |-> (u != '0))
    else $error("reciprocal is zero");

  a_last_holds: assert property (@(posedge clk) disable iff (rst)
    (yv && !adv) |=> (yv && $stable(yacc)))
    else $error("last stage changed while stalled");

endmodule
